@@ hdl/htfe_pkg.sv @@
`default_nettype none

package htfe_pkg;

	localparam int unsigned HTFE_FRAME_LEN = 30;
	localparam int unsigned HTFE_QDEPTH    = 2;

	localparam logic [31:0] HEADER_RST  = 32'hAAFF_0300;
	localparam logic [15:0] TRAILER_RST = 16'h55CC;

	typedef enum logic {
		REG_HEADER  = 1'b0,
		REG_TRAILER = 1'b1
	} htfe_reg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} htfe_qstat_t;

endpackage

`default_nettype wire

@@ hdl/header_trailer_frame_extractor_top.sv @@
// Frame extractor: one received byte is taken per clock while full is low. Each byte is shifted
// into a window of the last FRAME_LEN bytes; when the four oldest bytes equal header_pattern and
// the two newest equal trailer_pattern, the whole window is emitted as FRAME_LEN words, oldest
// byte first, with frame_last on the final word. Overlapping frames are each emitted. A matched
// frame is written into the queue and then loaded into the output shift register before its first
// word appears; words then leave at up to one per clock while pop is high. Up to two matched frames
// wait in a queue behind the one being sent; full is high while both queue slots are taken.
// Reset clears the window to zero bytes, which take part in matching.
`default_nettype none

module header_trailer_frame_extractor_top
	import htfe_pkg::*;
#(
	parameter int unsigned FRAME_LEN = HTFE_FRAME_LEN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_data,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       frame_byte,
	output logic             frame_last
);

	htfe_qstat_t               qstat;
	logic                      frame_wr;
	logic                      frame_rd;
	logic [FRAME_LEN-1:0][7:0] wr_frame;
	logic [FRAME_LEN-1:0][7:0] rd_frame;

	htfe_front #(.FRAME_LEN(FRAME_LEN)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rx_byte    (rx_byte),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.full       (full),
		.frame_wr   (frame_wr),
		.frame_data (wr_frame)
	);

	htfe_fifo #(.FRAME_LEN(FRAME_LEN)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (frame_wr),
		.wr_data (wr_frame),
		.rd      (frame_rd),
		.rd_data (rd_frame),
		.qstat   (qstat)
	);

	htfe_back #(.FRAME_LEN(FRAME_LEN)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.frame_data (rd_frame),
		.frame_rd   (frame_rd),
		.pop        (pop),
		.empty      (empty),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire

@@ hdl/htfe_front.sv @@
`default_nettype none

module htfe_front
	import htfe_pkg::*;
#(
	parameter int unsigned FRAME_LEN = HTFE_FRAME_LEN
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [7:0]                  rx_byte,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_idx,
	input  wire logic [31:0]                 cfg_data,
	input  wire htfe_qstat_t                 qstat,
	output logic                             full,
	output logic                             frame_wr,
	output logic [FRAME_LEN-1:0][7:0]        frame_data
);

	logic [FRAME_LEN-1:0][7:0] win_q;
	logic [FRAME_LEN-1:0][7:0] win_nxt;
	logic [31:0]               header_q;
	logic [15:0]               trailer_q;
	logic                      accept;
	logic                      match;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	// index 0 is the oldest byte
	assign win_nxt = {rx_byte, win_q[FRAME_LEN-1:1]};

	assign match = (win_nxt[0] == header_q[31:24]) && (win_nxt[1] == header_q[23:16]) &&
		(win_nxt[2] == header_q[15:8]) && (win_nxt[3] == header_q[7:0]) &&
		(win_nxt[FRAME_LEN-2] == trailer_q[15:8]) && (win_nxt[FRAME_LEN-1] == trailer_q[7:0]);

	assign frame_wr   = accept && match;
	assign frame_data = win_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (accept) begin
			win_q <= win_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RST;
			trailer_q <= TRAILER_RST;
		end else if (cfg_we) begin
			case (htfe_reg_t'(cfg_idx))
				REG_HEADER:  header_q  <= cfg_data;
				REG_TRAILER: trailer_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/htfe_fifo.sv @@
`default_nettype none

module htfe_fifo
	import htfe_pkg::*;
#(
	parameter int unsigned FRAME_LEN = HTFE_FRAME_LEN
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr,
	input  wire logic [FRAME_LEN-1:0][7:0]  wr_data,
	input  wire logic                       rd,
	output logic [FRAME_LEN-1:0][7:0]       rd_data,
	output htfe_qstat_t                     qstat
);

	localparam int unsigned PW = $clog2(HTFE_QDEPTH);
	localparam int unsigned CW = $clog2(HTFE_QDEPTH + 1);

	logic [FRAME_LEN-1:0][7:0] mem_q [HTFE_QDEPTH];
	logic [PW-1:0]             wptr_q;
	logic [PW-1:0]             rptr_q;
	logic [CW-1:0]             cnt_q;
	logic                      do_wr;
	logic                      do_rd;

	assign qstat.full  = (cnt_q == CW'(HTFE_QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_wr       = wr && !qstat.full;
	assign do_rd       = rd && !qstat.empty;
	assign rd_data     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(HTFE_QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(HTFE_QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/htfe_back.sv @@
`default_nettype none

module htfe_back
	import htfe_pkg::*;
#(
	parameter int unsigned FRAME_LEN = HTFE_FRAME_LEN
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire htfe_qstat_t                qstat,
	input  wire logic [FRAME_LEN-1:0][7:0]  frame_data,
	output logic                            frame_rd,
	input  wire logic                       pop,
	output logic                            empty,
	output logic [7:0]                      frame_byte,
	output logic                            frame_last
);

	localparam int unsigned RW = $clog2(FRAME_LEN + 1);

	logic [FRAME_LEN-1:0][7:0] shreg_q;
	logic [RW-1:0]             rem_q;
	logic                      busy_q;
	logic                      last;
	logic                      adv;

	assign last       = (rem_q == RW'(1));
	assign adv        = pop && busy_q;
	assign frame_rd   = !qstat.empty && (!busy_q || (adv && last));
	assign empty      = !busy_q;
	assign frame_byte = shreg_q[0];
	assign frame_last = last;

	always_ff @(posedge clk) begin
		if (frame_rd) begin
			shreg_q <= frame_data;
		end else if (adv) begin
			shreg_q <= {8'h00, shreg_q[FRAME_LEN-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (frame_rd) begin
			busy_q <= 1'b1;
			rem_q  <= RW'(FRAME_LEN);
		end else if (adv) begin
			rem_q <= rem_q - RW'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/htfe_checker.sv @@
`default_nettype none

module htfe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       push,
	input wire logic       full,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] frame_byte,
	input wire logic       frame_last
);

	// a waiting word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(frame_byte) && $stable(frame_last) && !empty))
		else $error("waiting word changed");

	// queue fills only after an accepted byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without accepted byte");

	// output drains only after the last word of a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop && frame_last))
		else $error("output emptied inside a frame");

	// a frame never breaks off before its last word
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !frame_last) |=> !empty)
		else $error("frame cut short");

endmodule

bind header_trailer_frame_extractor_top htfe_checker u_htfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.frame_byte (frame_byte),
	.frame_last (frame_last)
);

`default_nettype wire

@@ dv/header_trailer_frame_extractor_top_test.sv @@
`default_nettype none

module header_trailer_frame_extractor_top_test;
	import htfe_pkg::*;

	localparam int CYCLE_LIMIT = 10000000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 100;
	localparam int DRAIN_CYCLES = 8;

	typedef enum {SEQ_FRAMES, SEQ_BROKEN, SEQ_NOISE} seq_kind_t;
	typedef enum {PAT_DEFAULT, PAT_ZERO, PAT_ONES, PAT_RANDOM, PAT_REPEAT} pattern_set_t;

	class frame_scoreboard;
		typedef struct packed {
			logic [7:0] data;
			logic       last;
		} frame_word_t;

		logic [7:0]  window [HTFE_FRAME_LEN];
		logic [31:0] header;
		logic [15:0] trailer;
		frame_word_t expected_words [$];
		int          errors;

		function new();
			header = HEADER_RST;
			trailer = TRAILER_RST;
			foreach (window[i]) window[i] = 8'h00;
			errors = 0;
		endfunction

		function void write_reg(htfe_reg_t idx, logic [31:0] data);
			case (idx)
				REG_HEADER: header = data;
				REG_TRAILER: trailer = data[15:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] rx);
			frame_word_t w;
			for (int i = 0; i < HTFE_FRAME_LEN - 1; i++) window[i] = window[i + 1];
			window[HTFE_FRAME_LEN - 1] = rx;
			if ({window[0], window[1], window[2], window[3]} == header &&
			    {window[HTFE_FRAME_LEN - 2], window[HTFE_FRAME_LEN - 1]} == trailer) begin
				for (int i = 0; i < HTFE_FRAME_LEN; i++) begin
					w.data = window[i];
					w.last = (i == HTFE_FRAME_LEN - 1);
					expected_words.push_back(w);
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		task report(string msg);
			if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
			errors++;
		endtask

		task check_word(logic [7:0] data, logic last);
			frame_word_t w;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word %02h last %0b", data, last));
				return;
			end
			w = expected_words.pop_front();
			if (data !== w.data)
				report($sformatf("frame_byte %02h, expected %02h", data, w.data));
			if (last !== w.last)
				report($sformatf("frame_last %0b, expected %0b", last, w.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = 1'b0;
	logic [31:0] cfg_data = 32'h0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  frame_byte;
	logic        frame_last;

	frame_scoreboard sb;
	bit sender_burst = 1'b0;
	int hold_requests = 0;
	int cycles = 0;

	header_trailer_frame_extractor_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.empty(empty),
		.pop(pop),
		.frame_byte(frame_byte),
		.frame_last(frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int gap_len(bit burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(logic [7:0] rx);
		int g;
		g = gap_len(sender_burst);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= rx;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_byte(rx);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(htfe_reg_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random bytes; unless noise, header/trailer planted at random, often overlapping, starts
	task automatic send_sequence(int len, seq_kind_t kind);
		logic [7:0] seq_bytes [];
		int s, j, off;
		seq_bytes = new[len];
		foreach (seq_bytes[i]) seq_bytes[i] = 8'($urandom);
		s = 0;
		if (kind != SEQ_NOISE) begin
			repeat ($urandom_range(1, 3)) begin
				s = $urandom_range(0, len - HTFE_FRAME_LEN);
				for (int k = 0; k < 4; k++) seq_bytes[s + k] = sb.header[31 - 8 * k -: 8];
				seq_bytes[s + HTFE_FRAME_LEN - 2] = sb.trailer[15:8];
				seq_bytes[s + HTFE_FRAME_LEN - 1] = sb.trailer[7:0];
			end
		end
		if (kind == SEQ_BROKEN) begin
			j = $urandom_range(0, 5);
			off = (j < 4) ? j : HTFE_FRAME_LEN - 6 + j;
			seq_bytes[s + off] ^= 8'(1 << $urandom_range(0, 7));
		end
		foreach (seq_bytes[i]) send_byte(seq_bytes[i]);
	endtask

	initial begin
		int stall, hold_left, hold_served, mode_left;
		bit burst;
		stall = 0;
		hold_left = 0;
		hold_served = 0;
		mode_left = 0;
		burst = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_word(frame_byte, frame_last);
				stall = gap_len(burst);
			end
			if (mode_left == 0) begin
				burst = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0] directed_bytes [10];
		int random_sent, phase, r, len;
		pattern_set_t pat;
		seq_kind_t kind;
		logic [31:0] hdr, trl;
		logic [7:0] rb;
		directed_bytes = '{8'h55, 8'hCC, 8'h00, 8'hFF, 8'h80, 8'h7F,
			8'h01, 8'hFE, 8'h55, 8'hCC};
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero header against the reset window, trailer left at its reset value
		write_reg(REG_HEADER, 32'h0000_0000);
		foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
		drain();
		// stray high bits on the trailer write, zero bytes then match
		write_reg(REG_TRAILER, 32'hABCD_0000);
		repeat (3) send_byte(8'h00);
		drain();

		// receiver holds off while matching bytes keep coming
		random_sent = 0;
		hold_requests++;
		sender_burst = 1'b1;
		repeat (25) begin
			send_byte(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00);
			random_sent++;
		end
		sender_burst = 1'b0;
		drain();

		phase = 0;
		while (random_sent < 300) begin
			if (phase == 0) pat = PAT_ONES;
			else if (phase == 1) pat = PAT_DEFAULT;
			else pat = pattern_set_t'($urandom_range(0, 4));
			rb = 8'($urandom);
			case (pat)
				PAT_DEFAULT: begin
					hdr = HEADER_RST;
					trl = {16'h0, TRAILER_RST};
				end
				PAT_ZERO: begin
					hdr = 32'h0;
					trl = $urandom & 32'hFFFF_0000;
				end
				PAT_ONES: begin
					hdr = 32'hFFFF_FFFF;
					trl = 32'h0000_FFFF;
				end
				PAT_RANDOM: begin
					hdr = $urandom;
					trl = $urandom;
				end
				PAT_REPEAT: begin
					hdr = {4{rb}};
					trl = {16'h0, rb, rb};
				end
				default: begin
					hdr = HEADER_RST;
					trl = {16'h0, TRAILER_RST};
				end
			endcase
			write_reg(REG_HEADER, hdr);
			write_reg(REG_TRAILER, trl);
			sender_burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				r = $urandom_range(0, 9);
				kind = (r < 7) ? SEQ_FRAMES : (r < 9) ? SEQ_BROKEN : SEQ_NOISE;
				len = $urandom_range(HTFE_FRAME_LEN, 2 * HTFE_FRAME_LEN + 10);
				send_sequence(len, kind);
				random_sent += len;
			end
			drain();
			phase++;
		end

		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
